/* rtl/nfp_pkg.sv */
// shared types and constants of the nearest-point-to-footprint block
package nfp_pkg;

  localparam int unsigned SQ_BITS   = 40;
  localparam int unsigned EXT_BITS  = 16;
  localparam int unsigned ADDR_BITS = 5;
  localparam int unsigned IDX_BITS  = 3;
  localparam int unsigned DATA_BITS = 32;
  localparam int unsigned THR_BITS  = 2 * EXT_BITS;

  // unsigned width of an axis gap: the gap of a coordinate past an extent
  // reaches at most 2^(coord_bits-1) + 2^EXT_BITS - 1
  function automatic int unsigned gap_bits(int unsigned coord_bits);
    return ((coord_bits > EXT_BITS) ? coord_bits : EXT_BITS) + 1;
  endfunction

  typedef enum logic [IDX_BITS-1:0] {
    REG_CHECK_ENABLE      = 3'd0,
    REG_FRONT_EXTENT      = 3'd1,
    REG_REAR_EXTENT       = 3'd2,
    REG_HALF_WIDTH        = 3'd3,
    REG_CONTACT_THRESHOLD = 3'd4
  } reg_idx_e;

  localparam logic                RST_CHECK_ENABLE      = 1'b1;
  localparam logic [EXT_BITS-1:0] RST_FRONT_EXTENT      = 16'd5000;
  localparam logic [EXT_BITS-1:0] RST_REAR_EXTENT       = 16'd1500;
  localparam logic [EXT_BITS-1:0] RST_HALF_WIDTH        = 16'd1200;
  localparam logic [EXT_BITS-1:0] RST_CONTACT_THRESHOLD = 16'd500;
  localparam logic [THR_BITS-1:0] RST_THRESHOLD_SQ      = 32'd250000;

  // footprint rectangle extents
  typedef struct packed {
    logic [EXT_BITS-1:0] front_extent;
    logic [EXT_BITS-1:0] rear_extent;
    logic [EXT_BITS-1:0] half_width;
  } footprint_t;

  // settings used when a cloud is reported
  typedef struct packed {
    logic                check_enable;
    logic [THR_BITS-1:0] threshold_sq;
  } report_cfg_t;

endpackage

/* rtl/nfp_gap.sv */
// input register and per-axis gap stage
module nfp_gap #(
  parameter int unsigned COORD_BITS = 20
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  nfp_pkg::footprint_t                         footprint_i,
  input  logic                                        valid_i,
  output logic                                        ready_o,
  input  logic signed [COORD_BITS-1:0]                x_i,
  input  logic signed [COORD_BITS-1:0]                y_i,
  input  logic signed [COORD_BITS-1:0]                z_i,
  input  logic                                        last_i,
  output logic                                        valid_o,
  input  logic                                        ready_i,
  output logic [nfp_pkg::gap_bits(COORD_BITS)-1:0]    gap_x_o,
  output logic [nfp_pkg::gap_bits(COORD_BITS)-1:0]    gap_y_o,
  output logic signed [COORD_BITS-1:0]                x_o,
  output logic signed [COORD_BITS-1:0]                y_o,
  output logic signed [COORD_BITS-1:0]                z_o,
  output logic                                        last_o
);

  localparam int unsigned GW = nfp_pkg::gap_bits(COORD_BITS);
  localparam int unsigned EW = GW + 1;

  logic                         in_valid_q;
  logic signed [COORD_BITS-1:0] in_x_q, in_y_q, in_z_q;
  logic                         in_last_q;
  logic                         in_ready;

  logic                         gap_valid_q;
  logic        [GW-1:0]         gap_x_q, gap_y_q;
  logic signed [COORD_BITS-1:0] gap_px_q, gap_py_q, gap_pz_q;
  logic                         gap_last_q;
  logic                         gap_ready;

  logic signed [EW-1:0] xe, ye, front_e, rear_e, half_e;
  logic signed [EW-1:0] x_hi, x_lo, y_hi, y_lo;
  logic [GW-1:0] gap_x_d, gap_y_d;

  assign gap_ready = !gap_valid_q || ready_i;
  assign in_ready  = !in_valid_q || gap_ready;
  assign ready_o   = in_ready;

  assign xe      = $signed({{(EW-COORD_BITS){in_x_q[COORD_BITS-1]}}, in_x_q});
  assign ye      = $signed({{(EW-COORD_BITS){in_y_q[COORD_BITS-1]}}, in_y_q});
  assign front_e = $signed({{(EW-nfp_pkg::EXT_BITS){1'b0}}, footprint_i.front_extent});
  assign rear_e  = $signed({{(EW-nfp_pkg::EXT_BITS){1'b0}}, footprint_i.rear_extent});
  assign half_e  = $signed({{(EW-nfp_pkg::EXT_BITS){1'b0}}, footprint_i.half_width});

  // beyond the front edge / behind the rear edge, and past either side
  assign x_hi = xe - front_e;
  assign x_lo = -rear_e - xe;
  assign y_hi = ye - half_e;
  assign y_lo = -half_e - ye;

  // a gap stays below 2^GW, so GW unsigned bits hold it
  always_comb begin
    gap_x_d = '0;
    gap_y_d = '0;
    if (x_hi > 0) begin
      gap_x_d = x_hi[GW-1:0];
    end else if (x_lo > 0) begin
      gap_x_d = x_lo[GW-1:0];
    end
    if (y_hi > 0) begin
      gap_y_d = y_hi[GW-1:0];
    end else if (y_lo > 0) begin
      gap_y_d = y_lo[GW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      gap_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= valid_i;
      end
      if (gap_ready) begin
        gap_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && in_ready) begin
      in_x_q    <= x_i;
      in_y_q    <= y_i;
      in_z_q    <= z_i;
      in_last_q <= last_i;
    end
    if (in_valid_q && gap_ready) begin
      gap_x_q    <= gap_x_d;
      gap_y_q    <= gap_y_d;
      gap_px_q   <= in_x_q;
      gap_py_q   <= in_y_q;
      gap_pz_q   <= in_z_q;
      gap_last_q <= in_last_q;
    end
  end

  assign valid_o = gap_valid_q;
  assign gap_x_o = gap_x_q;
  assign gap_y_o = gap_y_q;
  assign x_o     = gap_px_q;
  assign y_o     = gap_py_q;
  assign z_o     = gap_pz_q;
  assign last_o  = gap_last_q;

endmodule

/* rtl/nfp_dist.sv */
// squaring stage and saturating sum stage of the squared distance
module nfp_dist #(
  parameter int unsigned COORD_BITS = 20
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  output logic                                     ready_o,
  input  logic [nfp_pkg::gap_bits(COORD_BITS)-1:0] gap_x_i,
  input  logic [nfp_pkg::gap_bits(COORD_BITS)-1:0] gap_y_i,
  input  logic signed [COORD_BITS-1:0]             x_i,
  input  logic signed [COORD_BITS-1:0]             y_i,
  input  logic signed [COORD_BITS-1:0]             z_i,
  input  logic                                     last_i,
  output logic                                     valid_o,
  input  logic                                     ready_i,
  output logic        [nfp_pkg::SQ_BITS-1:0]       sq_dist_o,
  output logic signed [COORD_BITS-1:0]             x_o,
  output logic signed [COORD_BITS-1:0]             y_o,
  output logic signed [COORD_BITS-1:0]             z_o,
  output logic                                     last_o
);

  localparam int unsigned SQ = nfp_pkg::SQ_BITS;
  localparam int unsigned GW = nfp_pkg::gap_bits(COORD_BITS);
  localparam int unsigned PB = 2 * GW;
  localparam int unsigned PW = (PB > SQ + 1) ? PB : SQ + 1;

  logic [PB-1:0]           prod_x, prod_y;
  logic [PW-1:0]           prod_x_ext, prod_y_ext;
  logic [SQ-1:0]           sat_x, sat_y;
  logic [SQ:0]             sum;
  logic [SQ-1:0]           sum_sat;

  logic                         sq_valid_q;
  logic [SQ-1:0]                sq_x_q, sq_y_q;
  logic signed [COORD_BITS-1:0] sq_px_q, sq_py_q, sq_pz_q;
  logic                         sq_last_q;
  logic                         sq_ready;

  logic                         sum_valid_q;
  logic [SQ-1:0]                sum_q;
  logic signed [COORD_BITS-1:0] sum_px_q, sum_py_q, sum_pz_q;
  logic                         sum_last_q;
  logic                         sum_ready;

  assign prod_x     = PB'(gap_x_i) * PB'(gap_x_i);
  assign prod_y     = PB'(gap_y_i) * PB'(gap_y_i);
  assign prod_x_ext = PW'(prod_x);
  assign prod_y_ext = PW'(prod_y);
  // each square clips at the top of the distance range
  assign sat_x = (|prod_x_ext[PW-1:SQ]) ? {SQ{1'b1}} : prod_x_ext[SQ-1:0];
  assign sat_y = (|prod_y_ext[PW-1:SQ]) ? {SQ{1'b1}} : prod_y_ext[SQ-1:0];

  assign sum     = {1'b0, sq_x_q} + {1'b0, sq_y_q};
  assign sum_sat = sum[SQ] ? {SQ{1'b1}} : sum[SQ-1:0];

  assign sum_ready = !sum_valid_q || ready_i;
  assign sq_ready  = !sq_valid_q || sum_ready;
  assign ready_o   = sq_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q  <= 1'b0;
      sum_valid_q <= 1'b0;
    end else begin
      if (sq_ready) begin
        sq_valid_q <= valid_i;
      end
      if (sum_ready) begin
        sum_valid_q <= sq_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && sq_ready) begin
      sq_x_q    <= sat_x;
      sq_y_q    <= sat_y;
      sq_px_q   <= x_i;
      sq_py_q   <= y_i;
      sq_pz_q   <= z_i;
      sq_last_q <= last_i;
    end
    if (sq_valid_q && sum_ready) begin
      sum_q      <= sum_sat;
      sum_px_q   <= sq_px_q;
      sum_py_q   <= sq_py_q;
      sum_pz_q   <= sq_pz_q;
      sum_last_q <= sq_last_q;
    end
  end

  assign valid_o   = sum_valid_q;
  assign sq_dist_o = sum_q;
  assign x_o       = sum_px_q;
  assign y_o       = sum_py_q;
  assign z_o       = sum_pz_q;
  assign last_o    = sum_last_q;

endmodule

/* rtl/nfp_track.sv */
// running minimum of one cloud and the result register
module nfp_track #(
  parameter int unsigned COORD_BITS = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  nfp_pkg::report_cfg_t               cfg_i,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic        [nfp_pkg::SQ_BITS-1:0] sq_dist_i,
  input  logic signed [COORD_BITS-1:0]       x_i,
  input  logic signed [COORD_BITS-1:0]       y_i,
  input  logic signed [COORD_BITS-1:0]       z_i,
  input  logic                               last_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               nearest_valid_o,
  output logic                               obstacle_found_o,
  output logic        [nfp_pkg::SQ_BITS-1:0] nearest_sq_distance_o,
  output logic signed [COORD_BITS-1:0]       nearest_x_o,
  output logic signed [COORD_BITS-1:0]       nearest_y_o,
  output logic signed [COORD_BITS-1:0]       nearest_z_o
);

  localparam int unsigned SQ = nfp_pkg::SQ_BITS;

  logic [SQ-1:0]                best_q, best_d;
  logic signed [COORD_BITS-1:0] best_x_q, best_x_d;
  logic signed [COORD_BITS-1:0] best_y_q, best_y_d;
  logic signed [COORD_BITS-1:0] best_z_q, best_z_d;
  logic                         seen_q;
  logic                         take;
  logic                         accept;
  logic                         report;
  logic                         hit;

  logic                         out_valid_q;
  logic                         res_valid_q, res_hit_q;
  logic [SQ-1:0]                res_sq_q;
  logic signed [COORD_BITS-1:0] res_x_q, res_y_q, res_z_q;

  // only a closing point has to wait for the result register
  assign ready_o = !last_i || !out_valid_q || out_ready_i;
  assign accept  = valid_i && ready_o;
  assign report  = accept && last_i;

  // first point of a cloud always wins, ties keep the earlier point
  assign take     = !seen_q || (sq_dist_i < best_q);
  assign best_d   = take ? sq_dist_i : best_q;
  assign best_x_d = take ? x_i : best_x_q;
  assign best_y_d = take ? y_i : best_y_q;
  assign best_z_d = take ? z_i : best_z_q;
  assign hit      = best_d < SQ'(cfg_i.threshold_sq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= '1;
      best_x_q    <= '0;
      best_y_q    <= '0;
      best_z_q    <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (report) begin
        best_q   <= '1;
        best_x_q <= '0;
        best_y_q <= '0;
        best_z_q <= '0;
        seen_q   <= 1'b0;
      end else if (accept) begin
        best_q   <= best_d;
        best_x_q <= best_x_d;
        best_y_q <= best_y_d;
        best_z_q <= best_z_d;
        seen_q   <= 1'b1;
      end
      if (report) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (report) begin
      res_valid_q <= cfg_i.check_enable;
      res_hit_q   <= cfg_i.check_enable && hit;
      res_sq_q    <= cfg_i.check_enable ? best_d : '0;
      res_x_q     <= cfg_i.check_enable ? best_x_d : '0;
      res_y_q     <= cfg_i.check_enable ? best_y_d : '0;
      res_z_q     <= cfg_i.check_enable ? best_z_d : '0;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign nearest_valid_o       = res_valid_q;
  assign obstacle_found_o      = res_hit_q;
  assign nearest_sq_distance_o = res_sq_q;
  assign nearest_x_o           = res_x_q;
  assign nearest_y_o           = res_y_q;
  assign nearest_z_o           = res_z_q;

endmodule

/* rtl/nearest_point_to_footprint.sv */
// top level: nearest point of a point cloud to the vehicle footprint
//
//   channel   direction  handshake                  payload
//   point     in         in_valid_i / in_ready_o    point_x/y/z_i, last_point_i
//   result    out        out_valid_o / out_ready_i  nearest_*_o, obstacle_found_o
//   config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// one point transfer per cycle, but for the stall of a last point noted below;
// a point passes four register stages (input, axis gap, square, sum) and the
// running minimum, and the last point of a cloud loads the result register
// reset restores the register reset values and an empty cloud at once
// only a last point stalls, and only while the previous result is still untaken;
// ordinary points keep flowing past a waiting result
module nearest_point_to_footprint #(
  parameter int unsigned COORD_BITS = 20
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // point stream
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [COORD_BITS-1:0]         point_x_i,
  input  logic signed [COORD_BITS-1:0]         point_y_i,
  input  logic signed [COORD_BITS-1:0]         point_z_i,
  input  logic                                 last_point_i,
  // result stream
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 nearest_valid_o,
  output logic                                 obstacle_found_o,
  output logic        [nfp_pkg::SQ_BITS-1:0]   nearest_sq_distance_o,
  output logic signed [COORD_BITS-1:0]         nearest_x_o,
  output logic signed [COORD_BITS-1:0]         nearest_y_o,
  output logic signed [COORD_BITS-1:0]         nearest_z_o,
  // register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [nfp_pkg::ADDR_BITS-1:0] paddr,
  input  logic        [nfp_pkg::DATA_BITS-1:0] pwdata,
  output logic        [nfp_pkg::DATA_BITS-1:0] prdata,
  output logic                                 pready
);

  localparam int unsigned EB = nfp_pkg::EXT_BITS;
  localparam int unsigned GW = nfp_pkg::gap_bits(COORD_BITS);

  // configuration registers
  logic                         check_enable_q;
  logic [EB-1:0]                front_extent_q;
  logic [EB-1:0]                rear_extent_q;
  logic [EB-1:0]                half_width_q;
  logic [EB-1:0]                contact_threshold_q;
  // threshold squared, kept ready so the report path holds no multiplier
  logic [nfp_pkg::THR_BITS-1:0] threshold_sq_q;
  logic [nfp_pkg::THR_BITS-1:0] threshold_sq_wr;

  nfp_pkg::reg_idx_e reg_idx;
  logic              reg_wr;

  nfp_pkg::footprint_t  footprint;
  nfp_pkg::report_cfg_t report_cfg;

  // stage links
  logic                          gap_valid, gap_ready;
  logic        [GW-1:0]          gap_x, gap_y;
  logic signed [COORD_BITS-1:0]  gap_px, gap_py, gap_pz;
  logic                          gap_last;
  logic                          dist_valid, dist_ready;
  logic [nfp_pkg::SQ_BITS-1:0]   dist_sq;
  logic signed [COORD_BITS-1:0]  dist_px, dist_py, dist_pz;
  logic                          dist_last;

  // register port: no wait states, write lands in the access phase
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite;
  assign reg_idx = nfp_pkg::reg_idx_e'(paddr[nfp_pkg::ADDR_BITS-1:2]);

  assign threshold_sq_wr = nfp_pkg::THR_BITS'(pwdata[EB-1:0]) *
                           nfp_pkg::THR_BITS'(pwdata[EB-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_enable_q      <= nfp_pkg::RST_CHECK_ENABLE;
      front_extent_q      <= nfp_pkg::RST_FRONT_EXTENT;
      rear_extent_q       <= nfp_pkg::RST_REAR_EXTENT;
      half_width_q        <= nfp_pkg::RST_HALF_WIDTH;
      contact_threshold_q <= nfp_pkg::RST_CONTACT_THRESHOLD;
      threshold_sq_q      <= nfp_pkg::RST_THRESHOLD_SQ;
    end else if (reg_wr) begin
      case (reg_idx)
        nfp_pkg::REG_CHECK_ENABLE: begin
          check_enable_q <= pwdata[0];
        end
        nfp_pkg::REG_FRONT_EXTENT: begin
          front_extent_q <= pwdata[EB-1:0];
        end
        nfp_pkg::REG_REAR_EXTENT: begin
          rear_extent_q <= pwdata[EB-1:0];
        end
        nfp_pkg::REG_HALF_WIDTH: begin
          half_width_q <= pwdata[EB-1:0];
        end
        nfp_pkg::REG_CONTACT_THRESHOLD: begin
          contact_threshold_q <= pwdata[EB-1:0];
          threshold_sq_q      <= threshold_sq_wr;
        end
        default: begin
          // addresses past the register list are ignored
        end
      endcase
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    case (reg_idx)
      nfp_pkg::REG_CHECK_ENABLE:      prdata = nfp_pkg::DATA_BITS'(check_enable_q);
      nfp_pkg::REG_FRONT_EXTENT:      prdata = nfp_pkg::DATA_BITS'(front_extent_q);
      nfp_pkg::REG_REAR_EXTENT:       prdata = nfp_pkg::DATA_BITS'(rear_extent_q);
      nfp_pkg::REG_HALF_WIDTH:        prdata = nfp_pkg::DATA_BITS'(half_width_q);
      nfp_pkg::REG_CONTACT_THRESHOLD: prdata = nfp_pkg::DATA_BITS'(contact_threshold_q);
      default:                        prdata = '0;
    endcase
  end

  assign footprint.front_extent = front_extent_q;
  assign footprint.rear_extent  = rear_extent_q;
  assign footprint.half_width   = half_width_q;

  // enable is only looked at when the last point reaches the minimum stage
  assign report_cfg.check_enable = check_enable_q;
  assign report_cfg.threshold_sq = threshold_sq_q;

  // input register and distance outside the rectangle along each axis
  nfp_gap #(
    .COORD_BITS (COORD_BITS)
  ) u_gap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .footprint_i (footprint),
    .valid_i     (in_valid_i),
    .ready_o     (in_ready_o),
    .x_i         (point_x_i),
    .y_i         (point_y_i),
    .z_i         (point_z_i),
    .last_i      (last_point_i),
    .valid_o     (gap_valid),
    .ready_i     (gap_ready),
    .gap_x_o     (gap_x),
    .gap_y_o     (gap_y),
    .x_o         (gap_px),
    .y_o         (gap_py),
    .z_o         (gap_pz),
    .last_o      (gap_last)
  );

  // squares, then their sum, both clipped to 40 bits
  nfp_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (gap_valid),
    .ready_o   (gap_ready),
    .gap_x_i   (gap_x),
    .gap_y_i   (gap_y),
    .x_i       (gap_px),
    .y_i       (gap_py),
    .z_i       (gap_pz),
    .last_i    (gap_last),
    .valid_o   (dist_valid),
    .ready_i   (dist_ready),
    .sq_dist_o (dist_sq),
    .x_o       (dist_px),
    .y_o       (dist_py),
    .z_o       (dist_pz),
    .last_o    (dist_last)
  );

  // running minimum; a last point closes the cloud into the result register
  nfp_track #(
    .COORD_BITS (COORD_BITS)
  ) u_track (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_i                 (report_cfg),
    .valid_i               (dist_valid),
    .ready_o               (dist_ready),
    .sq_dist_i             (dist_sq),
    .x_i                   (dist_px),
    .y_i                   (dist_py),
    .z_i                   (dist_pz),
    .last_i                (dist_last),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .nearest_valid_o       (nearest_valid_o),
    .obstacle_found_o      (obstacle_found_o),
    .nearest_sq_distance_o (nearest_sq_distance_o),
    .nearest_x_o           (nearest_x_o),
    .nearest_y_o           (nearest_y_o),
    .nearest_z_o           (nearest_z_o)
  );

endmodule

/* rtl/nfp_checker.sv */
// port-level checker for the nearest-point block and its bind
module nfp_checker #(
  parameter int unsigned COORD_BITS = 20
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic                                 nearest_valid_o,
  input logic                                 obstacle_found_o,
  input logic        [nfp_pkg::SQ_BITS-1:0]   nearest_sq_distance_o,
  input logic signed [COORD_BITS-1:0]         nearest_x_o,
  input logic signed [COORD_BITS-1:0]         nearest_y_o,
  input logic signed [COORD_BITS-1:0]         nearest_z_o
);

  // a result held back stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  // a result held back keeps its fields
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(nearest_sq_distance_o) &&
      $stable(nearest_x_o) && $stable(nearest_y_o) && $stable(nearest_z_o) &&
      $stable(nearest_valid_o) && $stable(obstacle_found_o))
    else $error("result changed while stalled");

  // a disabled search reports an all-zero result
  a_disabled_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !nearest_valid_o |-> !obstacle_found_o &&
      nearest_sq_distance_o == '0 && nearest_x_o == '0 &&
      nearest_y_o == '0 && nearest_z_o == '0)
    else $error("disabled result carries data");

  // no result is offered as reset is released
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result right after reset");

endmodule

bind nearest_point_to_footprint nfp_checker #(
  .COORD_BITS (COORD_BITS)
) u_nfp_checker (.*);

/* verif/tb.sv */
// testbench for nearest_point_to_footprint: directed table, then random clouds
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COORD_BITS   = 20;
  localparam int unsigned HALF_PERIOD  = 2;
  localparam int unsigned RESET_CYCLES = 7;
  // percent of cycles in which either side holds back
  localparam int unsigned IDLE_PCT     = 27;
  // pipeline is five stages deep, leave some margin
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_POINTS = 110;
  localparam longint unsigned LIMIT_NS = 2_000_000;
  localparam longint unsigned SQ_MAX   = (64'd1 << nfp_pkg::SQ_BITS) - 64'd1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // one reported cloud
  typedef struct packed {
    logic                        nvalid;
    logic                        found;
    logic [nfp_pkg::SQ_BITS-1:0] sq_dist;
    coord_t                      x;
    coord_t                      y;
    coord_t                      z;
  } report_t;

  typedef enum logic [1:0] {ROW_POINT, ROW_KNOWN, ROW_WRITE} row_kind_e;

  // one row of the directed table: a point, a point with its report typed in,
  // or a register write
  typedef struct {
    row_kind_e                     kind;
    coord_t                        x;
    coord_t                        y;
    coord_t                        z;
    logic                          last;
    nfp_pkg::reg_idx_e             idx;
    logic [nfp_pkg::DATA_BITS-1:0] val;
    report_t                       known;
  } row_t;

  // dut ports
  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_ready_o;
  coord_t                          point_x_i;
  coord_t                          point_y_i;
  coord_t                          point_z_i;
  logic                            last_point_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic                            nearest_valid_o;
  logic                            obstacle_found_o;
  logic [nfp_pkg::SQ_BITS-1:0]     nearest_sq_distance_o;
  coord_t                          nearest_x_o;
  coord_t                          nearest_y_o;
  coord_t                          nearest_z_o;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [nfp_pkg::ADDR_BITS-1:0]   paddr;
  logic [nfp_pkg::DATA_BITS-1:0]   pwdata;
  logic [nfp_pkg::DATA_BITS-1:0]   prdata;
  logic                            pready;

  // shadow copy of the registers
  logic                            cfg_enable;
  logic [nfp_pkg::EXT_BITS-1:0]    cfg_front;
  logic [nfp_pkg::EXT_BITS-1:0]    cfg_rear;
  logic [nfp_pkg::EXT_BITS-1:0]    cfg_half;
  logic [nfp_pkg::EXT_BITS-1:0]    cfg_thr;

  // running minimum of the current cloud
  logic [nfp_pkg::SQ_BITS-1:0]     best_sq;
  coord_t                          best_x;
  coord_t                          best_y;
  coord_t                          best_z;
  logic                            best_seen;

  report_t                         expected_reports[$];
  row_t                            dir_rows[$];
  int unsigned                     mismatches = 0;
  // when set neither side idles
  bit                              quiet = 1'b0;

  nearest_point_to_footprint #(
    .COORD_BITS(COORD_BITS)
  ) u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .point_x_i            (point_x_i),
    .point_y_i            (point_y_i),
    .point_z_i            (point_z_i),
    .last_point_i         (last_point_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .nearest_valid_o      (nearest_valid_o),
    .obstacle_found_o     (obstacle_found_o),
    .nearest_sq_distance_o(nearest_sq_distance_o),
    .nearest_x_o          (nearest_x_o),
    .nearest_y_o          (nearest_y_o),
    .nearest_z_o          (nearest_z_o),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always begin
    #(HALF_PERIOD) clk_i = 1'b1;
    #(HALF_PERIOD) clk_i = 1'b0;
  end

  // hard stop in case a handshake never completes
  initial begin
    #(LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_search();
    best_sq   = SQ_MAX[nfp_pkg::SQ_BITS-1:0];
    best_x    = '0;
    best_y    = '0;
    best_z    = '0;
    best_seen = 1'b0;
  endfunction

  // squared distance outside [lo, hi] along one axis, zero inside, saturated
  function automatic logic [nfp_pkg::SQ_BITS-1:0] axis_sq(longint p, longint lo, longint hi);
    longint unsigned gap;
    longint unsigned sq;
    gap = 0;
    if (p > hi) begin
      gap = p - hi;
    end else if (p < lo) begin
      gap = lo - p;
    end
    sq = gap * gap;
    if (sq > SQ_MAX) sq = SQ_MAX;
    return sq[nfp_pkg::SQ_BITS-1:0];
  endfunction

  // folds one point into the running minimum; returns 1 when the point closes a cloud
  function automatic bit track_point(input coord_t x, input coord_t y, input coord_t z,
                                     input logic last, output report_t rep);
    longint unsigned d;
    d = axis_sq(x, -longint'(cfg_rear), longint'(cfg_front))
      + axis_sq(y, -longint'(cfg_half), longint'(cfg_half));
    if (d > SQ_MAX) d = SQ_MAX;
    // first point always taken, later ones only if strictly closer
    if (!best_seen || d < best_sq) begin
      best_sq   = d[nfp_pkg::SQ_BITS-1:0];
      best_x    = x;
      best_y    = y;
      best_z    = z;
      best_seen = 1'b1;
    end
    rep = '0;
    if (!last) return 1'b0;
    // search disabled: every field of the report stays zero
    if (cfg_enable && best_seen) begin
      rep.nvalid  = 1'b1;
      rep.found   = longint'(best_sq) < longint'(cfg_thr) * longint'(cfg_thr);
      rep.sq_dist = best_sq;
      rep.x       = best_x;
      rep.y       = best_y;
      rep.z       = best_z;
    end
    clear_search();
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [nfp_pkg::SQ_BITS-1:0] want,
                                      logic [nfp_pkg::SQ_BITS-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // directed table rows
  // ---------------------------------------------------------------------------

  function automatic void row_point(int x, int y, int z, bit last);
    dir_rows.push_back('{ROW_POINT, coord_t'(x), coord_t'(y), coord_t'(z), last,
                         nfp_pkg::REG_CHECK_ENABLE, '0, '0});
  endfunction

  // closing point whose report is typed in; coordinates echo the point unless disabled
  function automatic void row_known(int x, int y, int z, bit nvalid, bit found,
                                    longint unsigned sq);
    report_t k;
    k = '0;
    k.nvalid  = nvalid;
    k.found   = found;
    k.sq_dist = sq[nfp_pkg::SQ_BITS-1:0];
    if (nvalid) begin
      k.x = coord_t'(x);
      k.y = coord_t'(y);
      k.z = coord_t'(z);
    end
    dir_rows.push_back('{ROW_KNOWN, coord_t'(x), coord_t'(y), coord_t'(z), 1'b1,
                         nfp_pkg::REG_CHECK_ENABLE, '0, k});
  endfunction

  function automatic void row_write(nfp_pkg::reg_idx_e idx, int unsigned val);
    dir_rows.push_back('{ROW_WRITE, '0, '0, '0, 1'b0, idx, val, '0});
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one point transfer; the expected report is queued when the transfer happens
  task automatic send_point(input coord_t x, input coord_t y, input coord_t z,
                            input logic last, input bit use_known, input report_t known);
    report_t rep;
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    point_x_i    <= x;
    point_y_i    <= y;
    point_z_i    <= z;
    last_point_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    if (track_point(x, y, z, last, rep)) begin
      expected_reports.push_back(use_known ? known : rep);
    end
  endtask

  // stop sending, wait for every report, then let the pipeline empty
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // register write with setup and access cycles, followed by a readback
  task automatic write_reg(input nfp_pkg::reg_idx_e idx,
                           input logic [nfp_pkg::DATA_BITS-1:0] val);
    settle();
    case (idx)
      nfp_pkg::REG_CHECK_ENABLE:      cfg_enable = val[0];
      nfp_pkg::REG_FRONT_EXTENT:      cfg_front  = val[nfp_pkg::EXT_BITS-1:0];
      nfp_pkg::REG_REAR_EXTENT:       cfg_rear   = val[nfp_pkg::EXT_BITS-1:0];
      nfp_pkg::REG_HALF_WIDTH:        cfg_half   = val[nfp_pkg::EXT_BITS-1:0];
      nfp_pkg::REG_CONTACT_THRESHOLD: cfg_thr    = val[nfp_pkg::EXT_BITS-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field($sformatf("%s readback", idx.name()), val, prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // mostly moderate extents, with the two extremes now and then
  function automatic int unsigned rand_extent();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) return 0;
    if (roll < 30) return 65535;
    return $urandom_range(8000);
  endfunction

  function automatic int edge_coord();
    case ($urandom_range(3))
      0:       return -(1 << (COORD_BITS - 1));
      1:       return (1 << (COORD_BITS - 1)) - 1;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  // one cloud of n points; most land around the footprint so the minimum keeps moving
  task automatic send_cloud(input int unsigned n);
    int      f, r, h, t, px, py, gap;
    report_t none;
    f    = int'(cfg_front);
    r    = int'(cfg_rear);
    h    = int'(cfg_half);
    t    = int'(cfg_thr);
    none = '0;
    px   = 0;
    py   = 0;
    for (int unsigned i = 0; i < n; i++) begin
      gap = int'($urandom_range(3 * t + 20));
      case ($urandom_range(9))
        // full range noise, toggles every bit
        0: begin
          px = int'($urandom);
          py = int'($urandom);
        end
        1: begin
          px = edge_coord();
          py = edge_coord();
        end
        // inside or on the rectangle
        2: begin
          px = int'($urandom_range(f + r)) - r;
          py = int'($urandom_range(2 * h)) - h;
        end
        // just past front or rear
        3: begin
          px = $urandom_range(1) ? f + gap : -r - gap;
          py = int'($urandom_range(2 * h)) - h;
        end
        // just past a side
        4: begin
          px = int'($urandom_range(f + r)) - r;
          py = $urandom_range(1) ? h + gap : -h - gap;
        end
        // off a corner
        5: begin
          px = $urandom_range(1) ? f + int'($urandom_range(t + 5))
                                 : -r - int'($urandom_range(t + 5));
          py = $urandom_range(1) ? h + gap : -h - gap;
        end
        // right at the contact threshold or one below it
        6: begin
          if ($urandom_range(1)) begin
            px = f + t - int'($urandom_range(1));
            py = 0;
          end else begin
            px = 0;
            py = -h - t + int'($urandom_range(1));
          end
        end
        // same x and y as the previous point: tie, the earlier one must stay
        7: ;
        // mirrored across the center line, equal distance
        8: py = -py;
        default: begin
          px = int'($urandom_range(400000)) - 200000;
          py = int'($urandom_range(400000)) - 200000;
        end
      endcase
      send_point(coord_t'(px), coord_t'(py), coord_t'($urandom), i == n - 1, 1'b0, none);
    end
  endtask

  // result side backpressure, changed at the falling edge
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // every result transfer is matched against the oldest expected report
  always @(posedge clk_i) begin : result_check
    report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_reports.size() == 0) begin
        $error("result transfer with no expected report waiting");
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        check_field("nearest_valid", want.nvalid, nearest_valid_o);
        check_field("obstacle_found", want.found, obstacle_found_o);
        check_field("nearest_sq_distance", want.sq_dist, nearest_sq_distance_o);
        check_field("nearest_x", want.x, nearest_x_o);
        check_field("nearest_y", want.y, nearest_y_o);
        check_field("nearest_z", want.z, nearest_z_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    report_t     none;
    int unsigned phase_pts;
    int unsigned n;
    int unsigned roll;
    none         = '0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    point_x_i    = '0;
    point_y_i    = '0;
    point_z_i    = '0;
    last_point_i = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    cfg_enable   = nfp_pkg::RST_CHECK_ENABLE;
    cfg_front    = nfp_pkg::RST_FRONT_EXTENT;
    cfg_rear     = nfp_pkg::RST_REAR_EXTENT;
    cfg_half     = nfp_pkg::RST_HALF_WIDTH;
    cfg_thr      = nfp_pkg::RST_CONTACT_THRESHOLD;
    clear_search();

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: footprint [-1500, 5000] x [-1200, 1200], contact 500
    row_known(0, 0, 7, 1, 1, 0);
    row_known(5000, 1200, -3, 1, 1, 0);           // on the corner counts as inside
    row_known(5500, 0, 0, 1, 0, 250000);          // exactly at contact, not below
    row_known(5499, 0, 0, 1, 1, 249001);
    row_known(-1500, -1200, 1, 1, 1, 0);
    row_known(0, -1700, 0, 1, 0, 250000);
    // coordinate extremes in one cloud
    row_point(524287, 524287, 524287, 0);
    row_point(-524288, -524288, -524288, 1);
    // three points at the same distance, the first must win
    row_point(6000, 0, 1, 0);
    row_point(-2500, 0, 2, 0);
    row_point(0, 2200, 3, 1);
    // a later closer point replaces the first
    row_point(9000, 9000, 0, 0);
    row_point(7000, 0, 0, 1);
    // search off: points still tracked but the report is all zero
    row_write(nfp_pkg::REG_CHECK_ENABLE, 0);
    row_point(0, 0, 5, 0);
    row_known(100, 100, 5, 0, 0, 0);
    // degenerate footprint and zero contact distance
    row_write(nfp_pkg::REG_CHECK_ENABLE, 1);
    row_write(nfp_pkg::REG_FRONT_EXTENT, 0);
    row_write(nfp_pkg::REG_REAR_EXTENT, 0);
    row_write(nfp_pkg::REG_HALF_WIDTH, 0);
    row_write(nfp_pkg::REG_CONTACT_THRESHOLD, 0);
    row_known(0, 0, 0, 1, 0, 0);
    row_known(3, 4, 9, 1, 0, 25);
    row_point(-3, -4, 2, 0);
    row_point(3, 4, 1, 1);
    // widest footprint and largest contact distance
    row_write(nfp_pkg::REG_FRONT_EXTENT, 65535);
    row_write(nfp_pkg::REG_REAR_EXTENT, 65535);
    row_write(nfp_pkg::REG_HALF_WIDTH, 65535);
    row_write(nfp_pkg::REG_CONTACT_THRESHOLD, 65535);
    row_known(65535, -65535, 0, 1, 1, 0);
    row_point(-524288, 0, 11, 1);
    row_point(524287, -524288, -1, 1);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].last,
                   dir_rows[i].kind == ROW_KNOWN, dir_rows[i].known);
      end
    end

    // random clouds, a new setting per phase; phase 0 restores the reset values,
    // phase 1 runs without any idling, phase 2 has the search switched off
    for (int phase = 0; phase < PHASES; phase++) begin
      quiet = (phase == 1);
      write_reg(nfp_pkg::REG_CHECK_ENABLE, (phase == 2) ? 0 : 1);
      write_reg(nfp_pkg::REG_FRONT_EXTENT,
                (phase == 0) ? nfp_pkg::RST_FRONT_EXTENT : rand_extent());
      write_reg(nfp_pkg::REG_REAR_EXTENT,
                (phase == 0) ? nfp_pkg::RST_REAR_EXTENT : rand_extent());
      write_reg(nfp_pkg::REG_HALF_WIDTH,
                (phase == 0) ? nfp_pkg::RST_HALF_WIDTH : rand_extent());
      write_reg(nfp_pkg::REG_CONTACT_THRESHOLD,
                (phase == 0) ? nfp_pkg::RST_CONTACT_THRESHOLD : rand_extent());
      phase_pts = 0;
      while (phase_pts < PHASE_POINTS) begin
        // mostly short clouds, some medium, a few long
        roll = $urandom_range(99);
        if (roll < 80) begin
          n = $urandom_range(6, 1);
        end else if (roll < 95) begin
          n = $urandom_range(20, 7);
        end else begin
          n = $urandom_range(60, 40);
        end
        send_cloud(n);
        phase_pts += n;
      end
    end

    quiet = 1'b0;
    settle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
